>>> rtl/mlpd_pkg.sv
// Package for the multimeter LCD packet decoder: word types, segment table,
// overload pattern and the unit, prefix and mode codes.
// No dependencies.
`default_nettype none

package mlpd_pkg;

   // Packet geometry
   localparam int PacketLen  = 14;
   localparam int StoreDepth = PacketLen - 1;
   localparam int CountWidth = 4;
   localparam int SegWidth   = 7;
   localparam int DigitCount = 10;

   typedef logic [3:0]            nibble_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [SegWidth-1:0]   seg_type;
   typedef logic [3:0]            digit_type;

   localparam count_type LastIndex    = count_type'(StoreDepth);
   localparam digit_type DigitUnknown = 4'd10;

   // Seven-segment codes of the digits 0..9
   localparam seg_type SegTable [DigitCount] = '{
      7'h7d, 7'h05, 7'h5b, 7'h1f, 7'h27, 7'h3e, 7'h7e, 7'h15, 7'h7f, 7'h3f
   };

   // Segment pattern that spells "0L"
   localparam logic [2:0] OvlThirdLow = 3'h7;
   localparam nibble_type OvlFourth   = 4'hd;
   localparam logic [2:0] OvlFifthLow = 3'h6;
   localparam nibble_type OvlSixth    = 4'h8;

   typedef enum logic [2:0] {
      UNIT_FARAD   = 3'd0,
      UNIT_OHM     = 3'd1,
      UNIT_AMP     = 3'd2,
      UNIT_HERTZ   = 3'd3,
      UNIT_VOLT    = 3'd4,
      UNIT_PERCENT = 3'd5,
      UNIT_CELSIUS = 3'd6,
      UNIT_UNKNOWN = 3'd7
   } unit_type;

   typedef enum logic [2:0] {
      PREFIX_NONE  = 3'd0,
      PREFIX_NANO  = 3'd1,
      PREFIX_MICRO = 3'd2,
      PREFIX_MILLI = 3'd3,
      PREFIX_KILO  = 3'd4,
      PREFIX_MEGA  = 3'd5
   } prefix_type;

   typedef enum logic [2:0] {
      MODE_DC          = 3'd0,
      MODE_AC          = 3'd1,
      MODE_CAPACITANCE = 3'd2,
      MODE_OHM         = 3'd3,
      MODE_FREQUENCY   = 3'd4,
      MODE_PERCENT     = 3'd5,
      MODE_TEMPERATURE = 3'd6
   } mode_type;

   // Input word
   typedef struct packed {
      logic [7:0] packet_byte;
      logic       first_byte;
   } req_type;

   // Result word: one decoded reading
   typedef struct packed {
      logic       overload;
      logic       negative;
      digit_type  digit_first;
      digit_type  digit_second;
      digit_type  digit_third;
      digit_type  digit_fourth;
      logic [1:0] point_position;
      unit_type   unit_code;
      prefix_type prefix_code;
      mode_type   mode_code;
      logic       diode;
   } reading_type;

   // Map a segment code to its digit, unknown codes to DigitUnknown
   function automatic digit_type seg_to_digit(input seg_type code);
      digit_type d;
      d = DigitUnknown;
      for (int k = 0; k < DigitCount; k++) begin
         if (code == SegTable[k]) begin
            d = digit_type'(k);
         end
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mlpd_if.sv
// Valid/ready channel interfaces for the decoder's input bytes and readings.
// Depends on mlpd_pkg.
`default_nettype none

interface mlpd_req_if;
   import mlpd_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mlpd_rsp_if;
   import mlpd_pkg::*;
   logic        valid;
   logic        ready;
   reading_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/multimeter_lcd_packet_decoder_top.sv
// Multimeter LCD packet decoder: gathers 14 segment nibbles, emits one reading.
// Depends on mlpd_pkg and the channel interfaces in mlpd_if.
//
//  channel  | dir | word                          | handshake
//  ---------+-----+-------------------------------+-------------------
//  req_ch   | in  | packet_byte, first_byte       | valid/ready
//  rsp_ch   | out | decoded reading (11 fields)   | valid/ready
//
// One word is taken per cycle while req_ch.ready is high. A decode register
// holds the last nibble of the fourteenth word, the decode logic feeds the
// output register. Reset clears the byte count and both valid bits; the nibble
// store is not cleared. When a reading waits in the output register and a
// second one waits for decode, req_ch.ready drops until rsp_ch moves.
`default_nettype none

module multimeter_lcd_packet_decoder_top (
   input  logic          clock,
   input  logic          reset,
   mlpd_req_if.sink      req_ch,
   mlpd_rsp_if.source    rsp_ch
);
   import mlpd_pkg::*;

   count_type   count_ff, count_in, count_eff;
   nibble_type  store_ff [StoreDepth];
   nibble_type  last_nib_ff;
   logic        dec_valid_ff, dec_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   reading_type rsp_data_ff;
   reading_type reading;
   nibble_type  nib;
   nibble_type  p [PacketLen];
   logic        accept, is_last, out_load;

   // Handshake
   assign out_load     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !dec_valid_ff || out_load;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Byte position, restarted by the start flag
   assign nib       = req_ch.data.packet_byte[3:0];
   assign count_eff = req_ch.data.first_byte ? '0 : count_ff;
   assign is_last   = (count_eff == LastIndex);
   assign count_in  = is_last ? '0 : count_eff + count_type'(1);

   assign dec_valid_in = (dec_valid_ff && !out_load) || (accept && is_last);
   assign rsp_valid_in = out_load ? dec_valid_ff : rsp_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         dec_valid_ff <= dec_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Store nibbles, hold the last one for decode, load the result word
   always_ff @(posedge clock) begin
      if (accept && !is_last) begin
         store_ff[count_eff] <= nib;
      end
      if (accept && is_last) begin
         last_nib_ff <= nib;
      end
      if (out_load && dec_valid_ff) begin
         rsp_data_ff <= reading;
      end
   end

   // Gather the whole packet
   always_comb begin
      for (int k = 0; k < StoreDepth; k++) begin
         p[k] = store_ff[k];
      end
      p[PacketLen-1] = last_nib_ff;
   end

   // Decode the packet
   always_comb begin
      reading = '0;
      reading.overload = (p[3][2:0] == OvlThirdLow) && (p[4] == OvlFourth) &&
                         (p[5][2:0] == OvlFifthLow) && (p[6] == OvlSixth);
      if (!reading.overload) begin
         reading.negative     = p[1][3];
         reading.digit_first  = seg_to_digit({p[1][2:0], p[2]});
         reading.digit_second = seg_to_digit({p[3][2:0], p[4]});
         reading.digit_third  = seg_to_digit({p[5][2:0], p[6]});
         reading.digit_fourth = seg_to_digit({p[7][2:0], p[8]});
      end

      // Decimal point: first lit point wins
      if (p[3][3])      reading.point_position = 2'd1;
      else if (p[5][3]) reading.point_position = 2'd2;
      else if (p[7][3]) reading.point_position = 2'd3;
      else              reading.point_position = 2'd0;

      reading.diode     = p[9][0];
      reading.mode_code = p[0][3] ? MODE_AC : MODE_DC;

      // Unit, with its mode where the unit fixes one
      if (p[11][3]) begin
         reading.unit_code = UNIT_FARAD;
         reading.mode_code = MODE_CAPACITANCE;
      end else if (p[11][2]) begin
         reading.unit_code = UNIT_OHM;
         reading.mode_code = MODE_OHM;
      end else if (p[12][3]) begin
         reading.unit_code = UNIT_AMP;
      end else if (p[12][1]) begin
         reading.unit_code = UNIT_HERTZ;
         reading.mode_code = MODE_FREQUENCY;
      end else if (p[12][2]) begin
         reading.unit_code = UNIT_VOLT;
      end else if (p[10][2]) begin
         reading.unit_code = UNIT_PERCENT;
         reading.mode_code = MODE_PERCENT;
      end else if (p[13][0]) begin
         reading.unit_code = UNIT_CELSIUS;
         reading.mode_code = MODE_TEMPERATURE;
      end else begin
         reading.unit_code = UNIT_UNKNOWN;
      end

      // Prefix: first lit segment wins
      if (p[9][2])       reading.prefix_code = PREFIX_NANO;
      else if (p[9][3])  reading.prefix_code = PREFIX_MICRO;
      else if (p[10][3]) reading.prefix_code = PREFIX_MILLI;
      else if (p[9][1])  reading.prefix_code = PREFIX_KILO;
      else if (p[10][1]) reading.prefix_code = PREFIX_MEGA;
      else               reading.prefix_code = PREFIX_NONE;
   end

endmodule

`default_nettype wire

>>> rtl/mlpd_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on mlpd_pkg and multimeter_lcd_packet_decoder_top.
`default_nettype none

module mlpd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mlpd_pkg::reading_type rsp_data
);
   import mlpd_pkg::*;

   // No reading right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reading shown right after reset");

   // Stalled reading holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled reading changed");

   // Overload clears sign and digits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overload |->
         !rsp_data.negative && rsp_data.digit_first == '0 &&
         rsp_data.digit_second == '0 && rsp_data.digit_third == '0 &&
         rsp_data.digit_fourth == '0)
      else $error("overload reading has sign or digits");

   // Digits stay within 0..9 or the unknown code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.digit_first <= DigitUnknown && rsp_data.digit_second <= DigitUnknown &&
         rsp_data.digit_third <= DigitUnknown && rsp_data.digit_fourth <= DigitUnknown)
      else $error("digit out of range");

endmodule

bind multimeter_lcd_packet_decoder_top mlpd_checker u_mlpd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

`default_nettype wire

>>> verif/mlpd_reading_tracker_pkg.sv
// Reading tracker for the LCD packet decoder bench: keeps its own nibble store,
// decodes each finished packet and checks the readings that come out.
// Depends on mlpd_pkg.
`timescale 1ns / 1ps

package mlpd_reading_tracker_pkg;
   import mlpd_pkg::*;

   localparam int ReportLimit = 10;

   class reading_tracker;
      nibble_type  nibbles [StoreDepth];
      count_type   stored;
      reading_type pending_readings [$];
      int          failures;
      int          readings_checked;
      int          overloads_checked;

      function new();
         stored            = '0;
         failures          = 0;
         readings_checked  = 0;
         overloads_checked = 0;
      endfunction

      // Look a 7-bit segment code up in the digit table
      function digit_type segment_value(input seg_type code);
         for (int k = 0; k < DigitCount; k++) begin
            if (code == SegTable[k]) begin
               return digit_type'(k);
            end
         end
         return DigitUnknown;
      endfunction

      // Decode the stored nibbles plus the last one into a reading
      function reading_type decode_packet(input nibble_type last);
         nibble_type  p [PacketLen];
         reading_type r;
         for (int k = 0; k < StoreDepth; k++) begin
            p[k] = nibbles[k];
         end
         p[StoreDepth] = last;
         r = '0;

         r.overload = (p[3][2:0] == OvlThirdLow) && (p[4] == OvlFourth) &&
                      (p[5][2:0] == OvlFifthLow) && (p[6] == OvlSixth);
         // Sign and digits stay zero on overload
         if (!r.overload) begin
            r.negative     = p[1][3];
            r.digit_first  = segment_value({p[1][2:0], p[2]});
            r.digit_second = segment_value({p[3][2:0], p[4]});
            r.digit_third  = segment_value({p[5][2:0], p[6]});
            r.digit_fourth = segment_value({p[7][2:0], p[8]});
         end

         if (p[3][3])      r.point_position = 2'd1;
         else if (p[5][3]) r.point_position = 2'd2;
         else if (p[7][3]) r.point_position = 2'd3;
         else              r.point_position = 2'd0;

         r.diode     = p[9][0];
         r.mode_code = p[0][3] ? MODE_AC : MODE_DC;

         // First lit unit segment wins; A, V and no unit keep AC/DC
         if (p[11][3]) begin
            r.unit_code = UNIT_FARAD;
            r.mode_code = MODE_CAPACITANCE;
         end else if (p[11][2]) begin
            r.unit_code = UNIT_OHM;
            r.mode_code = MODE_OHM;
         end else if (p[12][3]) begin
            r.unit_code = UNIT_AMP;
         end else if (p[12][1]) begin
            r.unit_code = UNIT_HERTZ;
            r.mode_code = MODE_FREQUENCY;
         end else if (p[12][2]) begin
            r.unit_code = UNIT_VOLT;
         end else if (p[10][2]) begin
            r.unit_code = UNIT_PERCENT;
            r.mode_code = MODE_PERCENT;
         end else if (p[13][0]) begin
            r.unit_code = UNIT_CELSIUS;
            r.mode_code = MODE_TEMPERATURE;
         end else begin
            r.unit_code = UNIT_UNKNOWN;
         end

         if (p[9][2])       r.prefix_code = PREFIX_NANO;
         else if (p[9][3])  r.prefix_code = PREFIX_MICRO;
         else if (p[10][3]) r.prefix_code = PREFIX_MILLI;
         else if (p[9][1])  r.prefix_code = PREFIX_KILO;
         else if (p[10][1]) r.prefix_code = PREFIX_MEGA;
         else               r.prefix_code = PREFIX_NONE;
         return r;
      endfunction

      // Note one accepted input word; a fourteenth byte queues a reading
      function void take_byte(input req_type w);
         nibble_type nib;
         nib = w.packet_byte[3:0];
         if (w.first_byte) begin
            stored = '0;
         end
         if (stored < LastIndex) begin
            nibbles[stored] = nib;
            stored = stored + 1'b1;
         end else begin
            pending_readings.push_back(decode_packet(nib));
            stored = '0;
         end
      endfunction

      function int waiting();
         return pending_readings.size();
      endfunction

      function string reading_text(input reading_type r);
         return $sformatf("ovl=%0d neg=%0d digits=%0d,%0d,%0d,%0d pt=%0d unit=%0d pfx=%0d mode=%0d diode=%0d",
                          r.overload, r.negative, r.digit_first, r.digit_second,
                          r.digit_third, r.digit_fourth, r.point_position,
                          r.unit_code, r.prefix_code, r.mode_code, r.diode);
      endfunction

      // Compare one accepted reading with the oldest expected one
      function void check_reading(input reading_type got);
         reading_type want;
         string       bad;
         if (pending_readings.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("ERROR: reading with none expected: %s", reading_text(got));
            end
            return;
         end
         want = pending_readings.pop_front();
         readings_checked++;
         if (want.overload) begin
            overloads_checked++;
         end
         bad = "";
         if (got.overload       != want.overload)       bad = {bad, " overload"};
         if (got.negative       != want.negative)       bad = {bad, " negative"};
         if (got.digit_first    != want.digit_first)    bad = {bad, " digit_first"};
         if (got.digit_second   != want.digit_second)   bad = {bad, " digit_second"};
         if (got.digit_third    != want.digit_third)    bad = {bad, " digit_third"};
         if (got.digit_fourth   != want.digit_fourth)   bad = {bad, " digit_fourth"};
         if (got.point_position != want.point_position) bad = {bad, " point_position"};
         if (got.unit_code      != want.unit_code)      bad = {bad, " unit_code"};
         if (got.prefix_code    != want.prefix_code)    bad = {bad, " prefix_code"};
         if (got.mode_code      != want.mode_code)      bad = {bad, " mode_code"};
         if (got.diode          != want.diode)          bad = {bad, " diode"};
         if (bad != "") begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("ERROR: reading %0d mismatch in%s", readings_checked, bad);
               $display("   expected %s", reading_text(want));
               $display("   actual   %s", reading_text(got));
            end
         end
      endfunction
   endclass

endpackage

>>> verif/testbench.sv
// Bench for the LCD packet decoder: directed and random packets with bursty
// input, a stalling result side and a reading tracker that checks each result.
// Depends on mlpd_pkg, mlpd_if and mlpd_reading_tracker_pkg.
`timescale 1ns / 1ps

module testbench;
   import mlpd_pkg::*;
   import mlpd_reading_tracker_pkg::*;

   localparam int TargetBytes = 750;
   localparam int CycleLimit  = 200000;
   localparam int HoldOffAt   = 200;
   localparam int HoldOffLen  = 400;
   localparam int DrainCycles = 8;

   typedef enum {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PERIODIC,
      STALL_COIN
   } stall_style_type;

   logic clock;
   logic reset;

   mlpd_req_if req_ch ();
   mlpd_rsp_if rsp_ch ();

   multimeter_lcd_packet_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   reading_tracker tracker;
   nibble_type     pkt [PacketLen];
   int             bytes_sent = 0;
   int             burst_left = 0;
   bit             quiet_phase = 0;
   int             cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Check every accepted reading
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_reading(rsp_ch.data);
      end
   end

   // Result side: stall in changing styles, with one long hold-off
   initial begin : receiver
      stall_style_type style;
      int style_left;
      int hold_left;
      int phase;
      bit held_off;
      style      = STALL_NONE;
      style_left = 0;
      hold_left  = 0;
      phase      = 0;
      held_off   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (!held_off && bytes_sent >= HoldOffAt) begin
            held_off  = 1;
            hold_left = HoldOffLen;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = stall_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(20, 120);
            end
            style_left--;
            case (style)
               STALL_NONE:     rsp_ch.ready <= 1'b1;
               STALL_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               STALL_PERIODIC: rsp_ch.ready <= (phase % 5 < 2);
               default:        rsp_ch.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // Offer one word at a falling edge, idling between random bursts
   task automatic send_word(input logic [7:0] value, input logic first);
      req_type w;
      int      gap;
      w.packet_byte = value;
      w.first_byte  = first;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = quiet_phase ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.take_byte(w);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Send the first count nibbles of pkt with random upper halves
   task automatic send_packet(input int count, input bit with_start);
      for (int i = 0; i < count; i++) begin
         send_word({4'($urandom_range(0, 15)), pkt[i]}, with_start && (i == 0));
      end
   endtask

   // Random packet: mostly valid digits, sparse unit and prefix segments
   task automatic roll_packet();
      seg_type code;
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 7) == 0) code = seg_type'($urandom);
         else                           code = SegTable[$urandom_range(0, DigitCount - 1)];
         pkt[1 + 2 * k] = {($urandom_range(0, 2) == 0), code[6:4]};
         pkt[2 + 2 * k] = code[3:0];
      end
      if ($urandom_range(0, 7) == 0) begin
         pkt[3][2:0] = OvlThirdLow;
         pkt[4]      = OvlFourth;
         pkt[5][2:0] = OvlFifthLow;
         pkt[6]      = OvlSixth;
      end
      pkt[0] = 4'($urandom);
      for (int k = 9; k < PacketLen; k++) begin
         pkt[k] = 4'($urandom & $urandom);
      end
   endtask

   initial begin : stimulus
      int n;
      tracker = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Overload with every flag lit, counted from reset without a start flag
      pkt = '{4'h8, 4'hf, 4'hf, 4'hf, 4'hd, 4'he, 4'h8,
              4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf};
      send_packet(PacketLen, 0);
      // Negative, digits 8 / unknown / 0 / 9, volts DC mega; cut short, restarted
      pkt = '{4'h0, 4'hf, 4'hf, 4'h0, 4'h0, 4'h7, 4'hd,
              4'h3, 4'hf, 4'h0, 4'h2, 4'h0, 4'h4, 4'h0};
      send_packet(4, 1);
      send_packet(PacketLen, 1);

      // Random part: mostly packets, some cut short, some noise
      while (bytes_sent < TargetBytes) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: begin
               n = $urandom_range(1, 6);
               repeat (n) send_word(8'($urandom), ($urandom_range(0, 3) == 0));
            end
            1: begin
               roll_packet();
               send_packet($urandom_range(1, PacketLen - 1), 1);
            end
            default: begin
               roll_packet();
               send_packet(PacketLen, ($urandom_range(0, 9) != 0));
            end
         endcase
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding readings
      while (tracker.waiting() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d packet bytes; checked %0d readings, %0d of them overload.",
               bytes_sent, tracker.readings_checked, tracker.overloads_checked);
      $display("Failures: %0d", tracker.failures);
      if (tracker.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/mlpd_pkg.sv
rtl/mlpd_if.sv
rtl/multimeter_lcd_packet_decoder_top.sv
rtl/mlpd_checker.sv
verif/mlpd_reading_tracker_pkg.sv
verif/testbench.sv
